>>> rtl/drlt_pkg.sv
package drlt_pkg;

	// field widths
	localparam int ADDR_W   = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 20;
	localparam int STRIDE_W = 13;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// defaults
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int TYPE_COUNT_DEF  = 4;
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;

	// request codes
	localparam logic [1:0] REQ_CREATE  = 2'd0;
	localparam logic [1:0] REQ_LOOKUP  = 2'd1;
	localparam logic [1:0] REQ_DESTROY = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	// register indexes
	localparam logic [1:0] REG_STRIDE_VIEW    = 2'd0;
	localparam logic [1:0] REG_STRIDE_SAMPLER = 2'd1;
	localparam logic [1:0] REG_STRIDE_RTV     = 2'd2;
	localparam logic [1:0] REG_STRIDE_DSV     = 2'd3;

	typedef struct packed {
		logic                is_gpu;
		logic [1:0]          etype;
		logic [KEY_W-1:0]    key;
		logic [ADDR_W-1:0]   start_addr;
		logic [ADDR_W-1:0]   end_addr;
	} entry_t;

	typedef struct packed {
		logic                start;
		logic [ADDR_W-1:0]   dividend;
		logic [STRIDE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [ADDR_W-1:0]   quotient;
		logic [STRIDE_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_RESID,
		ST_POST,
		ST_INDEX,
		ST_WR_CPU,
		ST_WR_GPU,
		ST_FIN
	} state_t;

endpackage

>>> rtl/drlt_ram.sv
module drlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/drlt_div.sv
module drlt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  drlt_pkg::div_req_t req,
	output drlt_pkg::div_rsp_t rsp
);
	import drlt_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [ADDR_W-1:0]    dq_q;
	logic [STRIDE_W-1:0]  rem_q;
	logic [STRIDE_W-1:0]  div_q;
	logic [STRIDE_W:0]    trial;
	logic                 fits;

	// one restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {rem_q, dq_q[ADDR_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			dq_q <= {dq_q[ADDR_W-2:0], fits};
			if (fits) begin
				rem_q <= STRIDE_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[STRIDE_W-1:0];
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dq_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/descriptor_range_lookup_table.sv
// Channel  | Signals                                         | Handshake
// request  | req_type heap_key heap_type cpu_start gpu_start | start & !busy
//          | descriptor_count shader_visible handle_kind     |
//          | handle_address                                  |
// result   | status found_key descriptor_index               | done, one cycle
// config   | psel penable pwrite paddr pwdata prdata pready  | APB, pready tied
// A valid request scans every table slot in order, ST_READ per free slot and
// ST_READ then ST_EVAL per occupied slot, set by the single read port of the
// entry memory. A lookup runs the shared bit-serial divider in ST_RESID per CPU
// candidate and in ST_INDEX for a GPU hit's index; creates add ST_WR_CPU/GPU.
// Reset clears the valid bits at once; no clearing pass is needed.
// busy stays high until the result beat; the receiver cannot stall it.
module descriptor_range_lookup_table #(
	parameter int TABLE_DEPTH = drlt_pkg::TABLE_DEPTH_DEF,
	parameter int TYPE_COUNT  = drlt_pkg::TYPE_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic [drlt_pkg::KEY_W-1:0]       heap_key,
	input  logic [1:0]                       heap_type,
	input  logic [drlt_pkg::ADDR_W-1:0]      cpu_start,
	input  logic [drlt_pkg::ADDR_W-1:0]      gpu_start,
	input  logic [drlt_pkg::CNT_W-1:0]       descriptor_count,
	input  logic                             shader_visible,
	input  logic                             handle_kind,
	input  logic [drlt_pkg::ADDR_W-1:0]      handle_address,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [drlt_pkg::KEY_W-1:0]       found_key,
	output logic [drlt_pkg::CNT_W-1:0]       descriptor_index,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [drlt_pkg::PADDR_W-1:0]     paddr,
	input  logic [drlt_pkg::PDATA_W-1:0]     pwdata,
	output logic [drlt_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import drlt_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

	state_t state_q, state_d;

	logic [3:0][STRIDE_W-1:0] stride_q;
	logic [TABLE_DEPTH-1:0]   valid_q;

	// latched request
	logic [1:0]          op_q;
	logic [KEY_W-1:0]    key_q;
	logic [1:0]          t_q;
	logic [ADDR_W-1:0]   cpu_q, gpu_q, handle_q;
	logic [CNT_W+STRIDE_W-1:0] len_q;
	logic                vis_q, kind_q;
	logic [STRIDE_W-1:0] s_q;

	// scan state
	logic [IW-1:0] idx_q;
	logic          cslot_v_q, gslot_v_q, f1_v_q, f2_v_q;
	logic [IW-1:0] cslot_q, gslot_q, f1_q, f2_q;
	logic          dcpu_q, dgpu_q;
	logic          best_v_q;
	logic [ADDR_W-1:0] best_start_q, best_end_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [CNT_W-1:0]  best_qt_q;

	// result
	logic [1:0]       res_status_q;
	logic [KEY_W-1:0] res_key_q;
	logic [CNT_W-1:0] res_idx_q;

	logic accept, cfg_wr, type_ok, cur_valid, at_last;
	logic [STRIDE_W-1:0] sel_stride, eff_stride;
	entry_t   rd_entry, wr_entry;
	logic     ram_we;
	logic [IW-1:0] ram_waddr;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     cand;
	logic     c_fin_v, g_need, g_free_v, create_ok;
	logic [IW-1:0] c_fin, g_free;
	logic     hit;

	assign accept  = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = PDATA_W'(stride_q[paddr[3:2]]);
	assign busy    = state_q != ST_IDLE;
	assign done    = state_q == ST_FIN;
	assign status  = res_status_q;
	assign found_key = res_key_q;
	assign descriptor_index = res_idx_q;

	assign type_ok    = {1'b0, heap_type} < 3'(TYPE_COUNT);
	assign sel_stride = stride_q[heap_type];
	assign eff_stride = (sel_stride == '0) ? STRIDE_W'(1) : sel_stride;
	assign cur_valid  = valid_q[idx_q];
	assign at_last    = idx_q == LAST;

	// lookup candidate among read entry
	assign cand = (rd_entry.is_gpu == kind_q) && (rd_entry.etype == t_q) &&
		(rd_entry.start_addr <= handle_q) &&
		(!best_v_q || rd_entry.start_addr > best_start_q);

	// slot choice after a create scan
	assign c_fin_v   = cslot_v_q || f1_v_q;
	assign c_fin     = cslot_v_q ? cslot_q : f1_q;
	assign g_need    = vis_q && !gslot_v_q;
	assign g_free_v  = cslot_v_q ? f1_v_q : f2_v_q;
	assign g_free    = cslot_v_q ? f1_q : f2_q;
	assign create_ok = c_fin_v && (!g_need || g_free_v);
	assign hit       = best_v_q && (handle_q < best_end_q);

	// entry memory
	always_comb begin
		wr_entry.is_gpu     = state_q == ST_WR_GPU;
		wr_entry.etype      = t_q;
		wr_entry.key        = key_q;
		wr_entry.start_addr = wr_entry.is_gpu ? gpu_q : cpu_q;
		wr_entry.end_addr   = wr_entry.start_addr + ADDR_W'(len_q);
	end
	assign ram_we    = (state_q == ST_WR_CPU) || (state_q == ST_WR_GPU);
	assign ram_waddr = (state_q == ST_WR_GPU) ? gslot_q : cslot_q;

	drlt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	// shared divider: residue checks and final index
	always_comb begin
		div_req.divisor  = s_q;
		div_req.start    = 1'b0;
		div_req.dividend = handle_q - rd_entry.start_addr;
		if (state_q == ST_EVAL && op_q == REQ_LOOKUP && cand && !kind_q) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_POST && op_q == REQ_LOOKUP && hit && kind_q) begin
			div_req.start    = 1'b1;
			div_req.dividend = handle_q - best_start_q;
		end
	end

	drlt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((req_type == REQ_DESTROY) ||
						((req_type == REQ_CREATE || req_type == REQ_LOOKUP) && type_ok)) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_READ: begin
				if (cur_valid) begin
					state_d = ST_EVAL;
				end else if (at_last) begin
					state_d = ST_POST;
				end
			end
			ST_EVAL: begin
				if (div_req.start) begin
					state_d = ST_RESID;
				end else begin
					state_d = at_last ? ST_POST : ST_READ;
				end
			end
			ST_RESID: begin
				if (div_rsp.done) begin
					state_d = at_last ? ST_POST : ST_READ;
				end
			end
			ST_POST: begin
				if (op_q == REQ_CREATE && create_ok) begin
					state_d = ST_WR_CPU;
				end else if (div_req.start) begin
					state_d = ST_INDEX;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_INDEX: begin
				if (div_rsp.done) begin
					state_d = ST_FIN;
				end
			end
			ST_WR_CPU: state_d = vis_q ? ST_WR_GPU : ST_FIN;
			ST_WR_GPU: state_d = ST_FIN;
			ST_FIN:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control: strides and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= {4{STRIDE_RST}};
			valid_q  <= '0;
		end else begin
			if (cfg_wr) begin
				stride_q[paddr[3:2]] <= pwdata[STRIDE_W-1:0];
			end
			if (state_q == ST_EVAL && op_q == REQ_DESTROY && rd_entry.key == key_q &&
				((!rd_entry.is_gpu && !dcpu_q) || (rd_entry.is_gpu && !dgpu_q))) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (state_q == ST_WR_CPU) begin
				valid_q[cslot_q] <= 1'b1;
			end
			if (state_q == ST_WR_GPU) begin
				valid_q[gslot_q] <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= req_type;
					key_q     <= heap_key;
					t_q       <= heap_type;
					cpu_q     <= cpu_start;
					gpu_q     <= gpu_start;
					handle_q  <= handle_address;
					vis_q     <= shader_visible;
					kind_q    <= handle_kind;
					s_q       <= eff_stride;
					len_q     <= (CNT_W+STRIDE_W)'(descriptor_count) *
						(CNT_W+STRIDE_W)'(eff_stride);
					idx_q     <= '0;
					cslot_v_q <= 1'b0;
					gslot_v_q <= 1'b0;
					f1_v_q    <= 1'b0;
					f2_v_q    <= 1'b0;
					dcpu_q    <= 1'b0;
					dgpu_q    <= 1'b0;
					best_v_q  <= 1'b0;
					res_status_q <= STAT_MISS;
					res_key_q    <= '0;
					res_idx_q    <= '0;
				end
			end
			ST_READ: begin
				if (!cur_valid) begin
					// track the two lowest free slots
					if (!f1_v_q) begin
						f1_v_q <= 1'b1;
						f1_q   <= idx_q;
					end else if (!f2_v_q) begin
						f2_v_q <= 1'b1;
						f2_q   <= idx_q;
					end
					if (!at_last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			ST_EVAL: begin
				case (op_q)
					REQ_CREATE: begin
						if (rd_entry.etype == t_q && !rd_entry.is_gpu &&
							rd_entry.start_addr == cpu_q && !cslot_v_q) begin
							cslot_v_q <= 1'b1;
							cslot_q   <= idx_q;
						end
						if (vis_q && rd_entry.etype == t_q && rd_entry.is_gpu &&
							rd_entry.start_addr == gpu_q && !gslot_v_q) begin
							gslot_v_q <= 1'b1;
							gslot_q   <= idx_q;
						end
					end
					REQ_DESTROY: begin
						if (rd_entry.key == key_q) begin
							if (!rd_entry.is_gpu) begin
								dcpu_q <= 1'b1;
							end else begin
								dgpu_q <= 1'b1;
							end
						end
					end
					REQ_LOOKUP: begin
						if (cand && kind_q) begin
							best_v_q     <= 1'b1;
							best_start_q <= rd_entry.start_addr;
							best_end_q   <= rd_entry.end_addr;
							best_key_q   <= rd_entry.key;
						end
					end
					default: ;
				endcase
				if (!div_req.start && !at_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_RESID: begin
				if (div_rsp.done) begin
					// CPU entry qualifies only on matching residue
					if (div_rsp.remainder == '0) begin
						best_v_q     <= 1'b1;
						best_start_q <= rd_entry.start_addr;
						best_end_q   <= rd_entry.end_addr;
						best_key_q   <= rd_entry.key;
						best_qt_q    <= div_rsp.quotient[CNT_W-1:0];
					end
					if (!at_last) begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			ST_POST: begin
				case (op_q)
					REQ_CREATE: begin
						cslot_q <= c_fin;
						if (g_need) begin
							gslot_q <= g_free;
						end
						res_status_q <= create_ok ? STAT_OK : STAT_FULL;
					end
					REQ_DESTROY: begin
						res_status_q <= (dcpu_q || dgpu_q) ? STAT_OK : STAT_MISS;
					end
					REQ_LOOKUP: begin
						if (hit) begin
							res_status_q <= STAT_OK;
							res_key_q    <= best_key_q;
							res_idx_q    <= best_qt_q;
						end
					end
					default: ;
				endcase
			end
			ST_INDEX: begin
				if (div_rsp.done) begin
					res_idx_q <= div_rsp.quotient[CNT_W-1:0];
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	// an accepted request holds busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("busy not raised after accept");
	// result beat lasts one cycle and leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done && !busy)
		else $error("result beat longer than one cycle");
	// a GPU entry is written only for a shader visible create
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_GPU) |-> (vis_q && $past(state_q) == ST_WR_CPU))
		else $error("unexpected GPU entry write");
	// the divider never restarts while a division is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESID || state_q == ST_INDEX) |-> !div_req.start)
		else $error("divider restarted while busy");
`endif

endmodule
